// File: sv/zss_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and signature decode for the ZIP signature scanner.
package zss_pkg;

    localparam int          SECTOR_BYTES   = 512;
    localparam logic [31:0] SECTOR_BYTES_W = 32'(SECTOR_BYTES);

    localparam logic [7:0] SIG_P     = 8'h50;
    localparam logic [7:0] SIG_K     = 8'h4B;
    localparam logic [7:0] LOC_B2    = 8'h03;
    localparam logic [7:0] LOC_B3    = 8'h04;
    localparam logic [7:0] CDIR_B2   = 8'h01;
    localparam logic [7:0] CDIR_B3   = 8'h02;
    localparam logic [7:0] EOCD_B2   = 8'h05;
    localparam logic [7:0] EOCD_B3   = 8'h06;

    localparam logic [1:0]  WIN_FULL    = 2'd3;
    localparam logic [31:0] POS_LAG     = 32'd3;
    localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;
    localparam logic [2:0]  FLAGS_RESET = 3'b111;

    typedef enum logic [1:0] {
        KIND_LOCAL = 2'd0,
        KIND_CDIR  = 2'd1,
        KIND_EOCD  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       sector_in_use;
        logic       last;
    } t_beat;

    typedef struct packed {
        logic [31:0] match_offset;
        t_kind       match_kind;
        logic [31:0] match_total;
    } t_result;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_kind_hit;

    function automatic t_kind_hit kind_of(input logic [7:0] b2, input logic [7:0] b3);
        t_kind_hit r;
        r.hit  = 1'b1;
        r.kind = KIND_LOCAL;
        priority if (b2 == LOC_B2 && b3 == LOC_B3) begin
            r.kind = KIND_LOCAL;
        end else if (b2 == CDIR_B2 && b3 == CDIR_B3) begin
            r.kind = KIND_CDIR;
        end else if (b2 == EOCD_B2 && b3 == EOCD_B3) begin
            r.kind = KIND_EOCD;
        end else begin
            r.hit = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: sv/zip_signature_scanner_top.sv
`timescale 1ns / 1ps
// Top level of the ZIP signature scanner.
//
// Input channel: one raw chunk byte per beat on i_data_byte with its sector
// in-use flag and a last flag on the final byte; i_valid offers, o_stall holds.
// Output channel: one beat per signature found (offset, kind, running total);
// o_valid offers, i_stall holds the beat steady.
// Config: i_start_sector_we writes i_start_sector, the chunk's first sector.
// Write it only between chunks with the pipeline drained.
// Throughput: one byte per cycle while o_stall is low. A match completed by a
// byte shows on o_valid once that byte's beat has passed the input register
// and then the result register, around the combinational window compare.
// A match is reported with the beat of its fourth byte; the window, position
// and match count clear after a beat with last set.
// Reset (synchronous, active low) empties both stages, clears the window and
// sets start sector to zero; o_stall is high while reset is held.
// When i_stall holds a result, the input register takes at most one more byte
// and holds it; o_stall stays high until the result is taken.
module zip_signature_scanner_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_sector_in_use,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_match_offset,
    output logic [1:0]  o_match_kind,
    output logic [31:0] o_match_total,
    input  logic        i_start_sector_we,
    input  logic [31:0] i_start_sector
);
    import zss_pkg::*;

    logic    in_vld;
    t_beat   beat;
    logic    out_free;
    logic    fire;
    logic    hit;
    t_result result;

    assign fire = in_vld && out_free;

    zss_in_reg u_in_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_data_byte     (i_data_byte),
        .i_sector_in_use (i_sector_in_use),
        .i_last          (i_last),
        .i_advance       (out_free),
        .o_stall         (o_stall),
        .o_vld           (in_vld),
        .o_beat          (beat)
    );

    zss_scan u_scan (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_beat            (beat),
        .i_start_sector_we (i_start_sector_we),
        .i_start_sector    (i_start_sector),
        .o_hit             (hit),
        .o_result          (result)
    );

    zss_out_reg u_out_reg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_hit          (hit),
        .i_result       (result),
        .i_stall        (i_stall),
        .o_free         (out_free),
        .o_valid        (o_valid),
        .o_match_offset (o_match_offset),
        .o_match_kind   (o_match_kind),
        .o_match_total  (o_match_total)
    );

endmodule

// File: sv/zss_in_reg.sv
`timescale 1ns / 1ps
// Input register stage: captures one byte beat and holds it until the scan takes it.
module zss_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_data_byte,
    input  logic          i_sector_in_use,
    input  logic          i_last,
    input  logic          i_advance,
    output logic          o_stall,
    output logic          o_vld,
    output zss_pkg::t_beat o_beat
);
    import zss_pkg::*;

    logic  r_vld;
    t_beat r_beat;
    logic  in_free;
    logic  accept;

    assign in_free = !r_vld || i_advance;
    assign o_stall = !i_rst_n || !in_free;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (i_advance) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat.data_byte     <= i_data_byte;
            r_beat.sector_in_use <= i_sector_in_use;
            r_beat.last          <= i_last;
        end
    end

    assign o_vld  = r_vld;
    assign o_beat = r_beat;

endmodule

// File: sv/zss_scan.sv
`timescale 1ns / 1ps
// Scan core: byte window, chunk state, signature compare and offset arithmetic.
module zss_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  zss_pkg::t_beat  i_beat,
    input  logic            i_start_sector_we,
    input  logic [31:0]     i_start_sector,
    output logic            o_hit,
    output zss_pkg::t_result o_result
);
    import zss_pkg::*;

    logic [31:0] r_start_sector;
    logic [23:0] r_window, n_window;
    logic [2:0]  r_flags,  n_flags;
    logic [1:0]  r_vcnt,   n_vcnt;
    logic [31:0] r_pos,    n_pos;
    logic [31:0] r_count,  n_count;

    t_kind_hit   sig;
    logic        hit;
    logic [31:0] count_inc;

    assign sig = kind_of(r_window[7:0], i_beat.data_byte);
    assign hit = (r_vcnt == WIN_FULL) && !r_flags[2] &&
                 (r_window[23:16] == SIG_P) && (r_window[15:8] == SIG_K) && sig.hit;
    assign count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 32'd1;

    always_comb begin
        o_result.match_offset = (r_start_sector * SECTOR_BYTES_W) + (r_pos - POS_LAG);
        o_result.match_kind   = sig.kind;
        o_result.match_total  = count_inc;
    end
    assign o_hit = hit;

    always_comb begin
        n_window = r_window;
        n_flags  = r_flags;
        n_vcnt   = r_vcnt;
        n_pos    = r_pos;
        n_count  = r_count;
        if (i_fire) begin
            if (i_beat.last) begin
                n_window = '0;
                n_flags  = FLAGS_RESET;
                n_vcnt   = '0;
                n_pos    = '0;
                n_count  = '0;
            end else begin
                n_window = {r_window[15:0], i_beat.data_byte};
                n_flags  = {r_flags[1:0], i_beat.sector_in_use};
                n_vcnt   = (r_vcnt == WIN_FULL) ? r_vcnt : r_vcnt + 2'd1;
                n_pos    = r_pos + 32'd1;
                if (hit) begin
                    n_count = count_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_sector <= '0;
            r_window       <= '0;
            r_flags        <= FLAGS_RESET;
            r_vcnt         <= '0;
            r_pos          <= '0;
            r_count        <= '0;
        end else begin
            if (i_start_sector_we) begin
                r_start_sector <= i_start_sector;
            end
            r_window <= n_window;
            r_flags  <= n_flags;
            r_vcnt   <= n_vcnt;
            r_pos    <= n_pos;
            r_count  <= n_count;
        end
    end

endmodule

// File: sv/zss_out_reg.sv
`timescale 1ns / 1ps
// Result register stage: holds one match beat until the receiver takes it.
module zss_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_hit,
    input  zss_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output logic [31:0]      o_match_offset,
    output logic [1:0]       o_match_kind,
    output logic [31:0]      o_match_total
);
    import zss_pkg::*;

    logic    r_vld;
    t_result r_res;

    assign o_free = !r_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_fire) begin
            r_vld <= i_hit;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_hit) begin
            r_res <= i_result;
        end
    end

    assign o_valid        = r_vld;
    assign o_match_offset = r_res.match_offset;
    assign o_match_kind   = r_res.match_kind;
    assign o_match_total  = r_res.match_total;

endmodule

// File: sv/zss_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the ZIP signature scanner and its bind.
module zss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_match_offset,
    input logic [1:0]  o_match_kind,
    input logic [31:0] o_match_total
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_match_offset) && $stable(o_match_kind)
                               && $stable(o_match_total))
        else $error("result beat changed while stalled");

    a_total_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_match_total != 32'd0)
        else $error("match beat with zero total");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty result register");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result beat without an input beat two cycles earlier");

endmodule

bind zip_signature_scanner_top zss_checker u_zss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_match_offset (o_match_offset),
    .o_match_kind   (o_match_kind),
    .o_match_total  (o_match_total)
);
